FILE: rtl/bfrs_pkg.sv
// Shared constants and types for the bitmap free-run scanner.
package bfrs_pkg;

  localparam int unsigned TableBytes = 4096;
  localparam int unsigned UnitShift  = 6;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned RunW     = 16;
  localparam int unsigned FreeW    = 16;
  localparam int unsigned AreaW    = 15;
  localparam int unsigned ResultW  = 22;
  localparam int unsigned BytesW   = $clog2(TableBytes + 1);
  localparam int unsigned BitCntW  = $clog2(ByteW + 1);

  // Summary of one bitmap byte, MSB first.
  typedef struct packed {
    logic               all_free;   // no used bit in the byte
    logic [BitCntW-1:0] lead;       // free bits before the first used bit
    logic [BitCntW-1:0] trail;      // free bits after the last used bit
    logic [BitCntW-1:0] zeros;      // free bits in the byte
    logic [2:0]         inner_max;  // longest run enclosed by used bits
    logic [1:0]         inner_cnt;  // runs enclosed by used bits
  } byte_info_t;

endpackage

FILE: rtl/bfrs_in_if.sv
// Request channel carrying bitmap bytes.
interface bfrs_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfrs_pkg::ByteW-1:0]   table_byte;
  logic                         last_byte;

  modport source (output valid, output table_byte, output last_byte, input ready);
  modport sink   (input valid, input table_byte, input last_byte, output ready);
endinterface

FILE: rtl/bfrs_out_if.sv
// Result channel carrying the free-space summary of one table.
interface bfrs_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfrs_pkg::ResultW-1:0]   largest_free;
  logic [bfrs_pkg::ResultW-1:0]   total_free;
  logic [bfrs_pkg::AreaW-1:0]     area_count;
  logic                           overflow;

  modport source (output valid, output largest_free, output total_free,
                  output area_count, output overflow, input ready);
  modport sink   (input valid, input largest_free, input total_free,
                  input area_count, input overflow, output ready);
endinterface

FILE: rtl/bfrs_byte_scan.sv
// Combinational run analysis of one bitmap byte.
module bfrs_byte_scan (
  input  logic [bfrs_pkg::ByteW-1:0] byte_i,
  output bfrs_pkg::byte_info_t       info_o
);
  import bfrs_pkg::*;

  logic               seen_one;
  logic [BitCntW-1:0] run;
  logic [BitCntW-1:0] lead;
  logic [BitCntW-1:0] zeros;
  logic [2:0]         inner_max;
  logic [1:0]         inner_cnt;

  always_comb begin
    seen_one  = 1'b0;
    run       = '0;
    lead      = '0;
    zeros     = '0;
    inner_max = '0;
    inner_cnt = '0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (byte_i[i]) begin
        if (!seen_one) begin
          lead = run;
        end else if (run != '0) begin
          // run bounded by used bits on both sides
          inner_cnt = inner_cnt + 2'd1;
          if (run > {1'b0, inner_max}) begin
            inner_max = run[2:0];
          end
        end
        seen_one = 1'b1;
        run      = '0;
      end else begin
        run   = run + BitCntW'(1);
        zeros = zeros + BitCntW'(1);
      end
    end
    if (!seen_one) begin
      lead = run;
    end
  end

  assign info_o.all_free  = ~seen_one;
  assign info_o.lead      = lead;
  assign info_o.trail     = run;
  assign info_o.zeros     = zeros;
  assign info_o.inner_max = inner_max;
  assign info_o.inner_cnt = inner_cnt;

endmodule

FILE: rtl/bitmap_free_run_scanner_core.sv
// Bitmap free-run scanner: takes one bitmap byte per cycle (MSB first, 1 used,
// 0 free) and, on the byte flagged last, delivers the largest free run and the
// total free bits, both shifted left by the unit size, the number of free runs
// and an overflow flag for bytes beyond the table capacity, which are ignored.
// A byte passes an input register and a single combinational update of the
// run counters, so a new byte is taken every cycle unless a last byte waits
// there; the result is registered as the last byte leaves the input register.
// The result register holds a waiting result; only a further last byte stalls
// behind it: one byte per cycle is sustained while results are taken.
module bitmap_free_run_scanner_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  bfrs_in_if.sink       in_i,
  bfrs_out_if.source    out_o
);
  import bfrs_pkg::*;

  // input register
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             out_free;

  // scan state
  logic [RunW-1:0]   cur_run_q, cur_run_d;
  logic [RunW-1:0]   longest_q, longest_d;
  logic [FreeW-1:0]  free_bits_q, free_bits_d;
  logic [AreaW-1:0]  runs_q, runs_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic              ovf_q, ovf_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [ResultW-1:0] largest_q;
  logic [ResultW-1:0] total_q;
  logic [AreaW-1:0]   area_q;
  logic               out_ovf_q;

  byte_info_t        info;
  logic              full;
  logic [RunW-1:0]   head;
  logic [RunW-1:0]   cur_n;
  logic [RunW-1:0]   longest_n;
  logic [FreeW-1:0]  free_n;
  logic [AreaW-1:0]  runs_n;
  logic              ovf_n;
  logic [RunW-1:0]   longest_fin;
  logic [AreaW-1:0]  runs_fin;

  bfrs_byte_scan u_byte_scan (
    .byte_i (s1_byte_q),
    .info_o (info)
  );

  assign out_free  = ~out_valid_q | out_o.ready;
  assign s1_adv    = s1_valid_q & (~s1_last_q | out_free);
  assign in_i.ready = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.table_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // fold one byte into the scan state
  always_comb begin
    full      = bytes_q >= BytesW'(TableBytes);
    head      = cur_run_q + RunW'(info.lead);
    cur_n     = cur_run_q;
    longest_n = longest_q;
    free_n    = free_bits_q;
    runs_n    = runs_q;
    ovf_n     = ovf_q;
    bytes_d   = bytes_q;
    if (full) begin
      ovf_n = 1'b1;
    end else begin
      bytes_d = bytes_q + BytesW'(1);
      free_n  = free_bits_q + FreeW'(info.zeros);
      if (info.all_free) begin
        cur_n = cur_run_q + RunW'(info.zeros);
      end else begin
        // run arriving from earlier bytes closes at the first used bit
        if (head > longest_n) begin
          longest_n = head;
        end
        if (RunW'(info.inner_max) > longest_n) begin
          longest_n = RunW'(info.inner_max);
        end
        runs_n = runs_q + AreaW'(head != '0) + AreaW'(info.inner_cnt);
        cur_n  = RunW'(info.trail);
      end
    end
    // close the run left open at the end of the table
    longest_fin = longest_n;
    runs_fin    = runs_n;
    if (cur_n != '0) begin
      runs_fin = runs_n + AreaW'(1);
      if (cur_n > longest_n) begin
        longest_fin = cur_n;
      end
    end
  end

  always_comb begin
    cur_run_d   = cur_run_q;
    longest_d   = longest_q;
    free_bits_d = free_bits_q;
    runs_d      = runs_q;
    ovf_d       = ovf_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        cur_run_d   = '0;
        longest_d   = '0;
        free_bits_d = '0;
        runs_d      = '0;
        ovf_d       = 1'b0;
      end else begin
        cur_run_d   = cur_n;
        longest_d   = longest_n;
        free_bits_d = free_n;
        runs_d      = runs_n;
        ovf_d       = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_run_q   <= '0;
      longest_q   <= '0;
      free_bits_q <= '0;
      runs_q      <= '0;
      bytes_q     <= '0;
      ovf_q       <= 1'b0;
    end else begin
      cur_run_q   <= cur_run_d;
      longest_q   <= longest_d;
      free_bits_q <= free_bits_d;
      runs_q      <= runs_d;
      ovf_q       <= ovf_d;
      if (s1_adv) begin
        bytes_q <= s1_last_q ? '0 : bytes_d;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      largest_q <= ResultW'(32'(longest_fin) << UnitShift);
      total_q   <= ResultW'(32'(free_n) << UnitShift);
      area_q    <= runs_fin;
      out_ovf_q <= ovf_n;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.largest_free = largest_q;
  assign out_o.total_free   = total_q;
  assign out_o.area_count   = area_q;
  assign out_o.overflow     = out_ovf_q;

  a_bytes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= BytesW'(TableBytes))
    else $error("byte count beyond table capacity");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_bits_q <= {bytes_q, 3'b000})
    else $error("free bits exceed bits scanned");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_run_q <= free_bits_q)
    else $error("open run longer than free total");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> bytes_q == BytesW'(TableBytes))
    else $error("overflow flagged before table full");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> bytes_q == '0 && cur_run_q == '0 && out_valid_q)
    else $error("scan state not cleared after last byte");

endmodule

FILE: sim/tb_bitmap_free_run_scanner_core.sv
// Testbench for the bitmap free-run scanner: directed and random tables checked against a predictor.
`timescale 1ns / 100ps

module tb_bitmap_free_run_scanner_core;
  import bfrs_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct {
    logic [ResultW-1:0] largest_free;
    logic [ResultW-1:0] total_free;
    logic [AreaW-1:0]   area_count;
    logic               overflow;
  } free_summary_t;

  // Tracks the scan of the table in progress and the summaries still owed.
  class free_space_board;
    logic [RunW-1:0]  run_now;
    logic [RunW-1:0]  run_max;
    logic [FreeW-1:0] free_cnt;
    logic [AreaW-1:0] run_cnt;
    logic [BytesW-1:0] byte_cnt;
    logic             overflowed;
    free_summary_t    summary_q[$];
    int unsigned      bytes_taken;
    int unsigned      summaries_checked;
    int unsigned      overflow_tables;
    int unsigned      errors;

    function new();
      clear_scan();
      bytes_taken = 0;
      summaries_checked = 0;
      overflow_tables = 0;
      errors = 0;
    endfunction

    function void clear_scan();
      run_now = '0;
      run_max = '0;
      free_cnt = '0;
      run_cnt = '0;
      byte_cnt = '0;
      overflowed = 1'b0;
    endfunction

    function void close_run();
      if (run_now != 0) begin
        if (run_now > run_max) run_max = run_now;
        run_cnt = run_cnt + 1'b1;
        run_now = '0;
      end
    endfunction

    function void note_byte(logic [ByteW-1:0] b, logic last);
      logic [63:0]   wide;
      free_summary_t s;
      bytes_taken++;
      if (byte_cnt >= TableBytes) begin
        overflowed = 1'b1;
      end else begin
        // MSB first: a free bit extends the run, a used bit closes it
        for (int i = ByteW - 1; i >= 0; i--) begin
          if (!b[i]) begin
            run_now = run_now + 1'b1;
            free_cnt = free_cnt + 1'b1;
          end else begin
            close_run();
          end
        end
        byte_cnt = byte_cnt + 1'b1;
      end
      if (last) begin
        close_run();
        wide = 64'(run_max) << UnitShift;
        s.largest_free = wide[ResultW-1:0];
        wide = 64'(free_cnt) << UnitShift;
        s.total_free = wide[ResultW-1:0];
        s.area_count = run_cnt;
        s.overflow = overflowed;
        if (overflowed) overflow_tables++;
        summary_q.push_back(s);
        clear_scan();
      end
    endfunction

    function void check_summary(free_summary_t got);
      free_summary_t want;
      if (summary_q.size() == 0) begin
        $error("summary with none pending: largest %0d total %0d areas %0d ovf %0b",
               got.largest_free, got.total_free, got.area_count, got.overflow);
        errors++;
        return;
      end
      want = summary_q.pop_front();
      summaries_checked++;
      if (got.largest_free !== want.largest_free) begin
        $error("largest_free: expected %0d, got %0d", want.largest_free, got.largest_free);
        errors++;
      end
      if (got.total_free !== want.total_free) begin
        $error("total_free: expected %0d, got %0d", want.total_free, got.total_free);
        errors++;
      end
      if (got.area_count !== want.area_count) begin
        $error("area_count: expected %0d, got %0d", want.area_count, got.area_count);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bfrs_in_if  in_ch ();
  bfrs_out_if out_ch ();

  bitmap_free_run_scanner_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  free_space_board board = new();

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_off_req;
  int unsigned tables_sent;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off when asked for
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    free_summary_t got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) board.note_byte(in_ch.table_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.largest_free = out_ch.largest_free;
        got.total_free = out_ch.total_free;
        got.area_count = out_ch.area_count;
        got.overflow = out_ch.overflow;
        board.check_summary(got);
      end
    end
  end

  // Watchdog: give up after a long stretch with no request or summary taken
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [ByteW-1:0] b, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.table_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    if (last) tables_sent++;
  endtask

  // Bias towards whole free or used bytes and lone bits to make long runs
  function automatic logic [ByteW-1:0] pick_bitmap_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(9))
      0, 1:    b = 8'h00;
      2, 3:    b = 8'hFF;
      4:       b = 8'h01 << $urandom_range(7);
      5:       b = ~(8'h01 << $urandom_range(7));
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic send_random_table(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(pick_bitmap_byte(), i == len - 1);
  endtask

  task automatic random_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned n_bytes);
    int unsigned start;
    start = board.bytes_taken;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    while (board.bytes_taken - start < n_bytes) begin
      if ($urandom_range(3) == 0) send_random_table(1);
      else send_random_table($urandom_range(24, 2));
    end
  endtask

  initial begin : main
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_off_req = 0;
    tables_sent = 0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.table_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all free, all used, runs open at table end, runs across bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h81, 1'b1);
    send_byte(8'h7E, 1'b1);
    send_byte(8'hE7, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    random_phase(0, 0, 300);
    random_phase(58, 0, 300);
    random_phase(0, 58, 300);
    random_phase(29, 29, 300);

    // Hold off the receiver while short tables keep arriving, so input stalls
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_off_req = HoldOffCycles;
    for (int i = 0; i < 20; i++) send_random_table($urandom_range(3, 1));

    // Capacity: a table free to the last bit, then bytes beyond capacity
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    for (int unsigned i = 0; i < TableBytes; i++) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);
    in_ch.valid <= 1'b0;

    repeat (4) @(posedge clk_i);
    while (board.summary_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("scanned %0d tables, %0d bitmap bytes; %0d summaries checked",
             tables_sent, board.bytes_taken, board.summaries_checked);
    $display("covered idle/stall mixes, receiver hold-off and a capacity overrun (%0d flagged)",
             board.overflow_tables);
    if (board.errors == 0 && board.summary_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bfrs_pkg.sv
rtl/bfrs_in_if.sv
rtl/bfrs_out_if.sv
rtl/bfrs_byte_scan.sv
rtl/bitmap_free_run_scanner_core.sv
sim/tb_bitmap_free_run_scanner_core.sv
